/* rtl/uar_pkg.sv */
// Shared types and constants for the unsigned-to-ASCII radix formatter.
// No dependencies; every other file imports this package.
`default_nettype none

package uar_pkg;

  localparam int unsigned IN_VALUE_W = 64;
  localparam int unsigned CHAR_W     = 8;

  typedef enum logic [1:0] {
    CMD_DEC    = 2'd0,
    CMD_OCT    = 2'd1,
    CMD_HEX_LO = 2'd2,
    CMD_HEX_UP = 2'd3
  } cmd_e;

  // size_mode codes; the fourth code keeps all bits like SIZE_LONG
  localparam logic [1:0] SIZE_INT   = 2'd0;
  localparam logic [1:0] SIZE_LONG  = 2'd1;
  localparam logic [1:0] SIZE_SHORT = 2'd2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_X = 8'h58;

  // Control part of a queued request: radix and number of prefix characters
  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] pfx_cnt;
  } job_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d, logic upper);
    logic [CHAR_W-1:0] base;
    if (d < 4'd10) begin
      return ASCII_ZERO + {4'b0, d};
    end
    base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

`default_nettype wire

/* rtl/uar_if.sv */
// Handshake channel interfaces for the formatter: request in, characters out.
// Depends on uar_pkg for field widths.
`default_nettype none

interface uar_in_if import uar_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic [IN_VALUE_W-1:0] value;
  logic [1:0]            size_mode;
  logic                  alt_form;

  modport source (output valid, cmd, value, size_mode, alt_form, input ready);
  modport sink   (input valid, cmd, value, size_mode, alt_form, output ready);
endinterface

interface uar_out_if import uar_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

`default_nettype wire

/* rtl/unsigned_to_ascii_radix.sv */
// Unsigned integer to ASCII formatter (printf style, radix 10/8/16).
// Decimal runs the shift-add-3 conversion before the leading-zero strip; octal/hex go
// straight to the strip, over D = ceil(VALUE_BITS/3) digit slots (longer numbers strip
// fewer leading zeros). Then one character per cycle while the receiver is ready.
// One request at a time in the digit engine (VALUE_BITS shift-add-3 steps for decimal),
// a two-entry queue ahead. Reset clears the queue, the engine state and the output register.
`default_nettype none

module unsigned_to_ascii_radix import uar_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uar_in_if.sink     in_i,
  uar_out_if.source  out_o
);

  localparam int unsigned CTL_W  = $bits(job_ctl_t);
  localparam int unsigned DATA_W = CTL_W + VALUE_BITS;

  logic                  push_valid, push_ready;
  job_ctl_t              push_ctl;
  logic [VALUE_BITS-1:0] push_value;
  logic                  pop_valid, pop_ready;
  logic [DATA_W-1:0]     pop_data;
  job_ctl_t              pop_ctl;
  logic [VALUE_BITS-1:0] pop_value;

  uar_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_ctl_o   (push_ctl),
    .push_value_o (push_value)
  );

  uar_queue #(.DATA_W(DATA_W)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_ctl, push_value}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_ctl   = job_ctl_t'(pop_data[DATA_W-1 -: CTL_W]);
  assign pop_value = pop_data[VALUE_BITS-1:0];

  uar_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_ready_o (pop_ready),
    .q_ctl_i   (pop_ctl),
    .q_value_i (pop_value),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

/* rtl/uar_front.sv */
// Front end: accepts a request, limits and cuts the value by size mode,
// and works out the radix prefix length. Depends on uar_pkg and uar_if.
`default_nettype none

module uar_front import uar_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  uar_in_if.sink                 in_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output job_ctl_t               push_ctl_o,
  output logic [VALUE_BITS-1:0]  push_value_o
);

  logic [VALUE_BITS-1:0] uncut;
  logic [VALUE_BITS-1:0] cut;
  cmd_e                  cmd;

  assign uncut = in_i.value[VALUE_BITS-1:0];
  assign cmd   = cmd_e'(in_i.cmd);

  always_comb begin
    cut = uncut;
    for (int b = 0; b < VALUE_BITS; b++) begin
      if ((b >= 32) && (in_i.size_mode == SIZE_INT)) begin
        cut[b] = 1'b0;
      end
      if ((b >= 16) && (in_i.size_mode == SIZE_SHORT)) begin
        cut[b] = 1'b0;
      end
    end
  end

  // prefix follows the uncut value, so a value cut to zero keeps it
  always_comb begin
    push_ctl_o.cmd     = cmd;
    push_ctl_o.pfx_cnt = 2'd0;
    if (in_i.alt_form && (uncut != '0)) begin
      unique case (cmd)
        CMD_DEC:                push_ctl_o.pfx_cnt = 2'd0;
        CMD_OCT:                push_ctl_o.pfx_cnt = 2'd1;
        CMD_HEX_LO, CMD_HEX_UP: push_ctl_o.pfx_cnt = 2'd2;
        default:                push_ctl_o.pfx_cnt = 2'd0;
      endcase
    end
  end

  assign push_valid_o = in_i.valid;
  assign push_value_o = cut;
  assign in_i.ready   = push_ready_i;

endmodule

`default_nettype wire

/* rtl/uar_queue.sv */
// Two-entry request queue between the front end and the digit engine.
// Depends on uar_pkg only through the wildcard import convention.
`default_nettype none

module uar_queue import uar_pkg::*; #(
  parameter int unsigned DATA_W = 68
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/uar_back.sv */
// Digit engine: binary to BCD by shift-add-3 for decimal, direct digit split
// for octal and hex, leading-zero strip, prefix and digit output.
// Depends on uar_pkg and uar_if.
`default_nettype none

module uar_back import uar_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  job_ctl_t              q_ctl_i,
  input  logic [VALUE_BITS-1:0] q_value_i,
  uar_out_if.source             out_o
);

  // octal needs the most digit slots; decimal fits in the same count
  localparam int unsigned NDIG   = (VALUE_BITS + 2) / 3;
  localparam int unsigned NDIG_W = $clog2(NDIG + 1);
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned OCT_W  = 3 * NDIG;
  localparam int unsigned HEX_W  = 4 * NDIG;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_PFX,
    ST_EMIT
  } state_e;

  state_e                      state_q, state_d;
  logic [NDIG-1:0][3:0]        dig_q, dig_d;
  logic [VALUE_BITS-1:0]       val_q, val_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [NDIG_W-1:0]           ndig_q, ndig_d;
  cmd_e                        cmd_q, cmd_d;
  logic [1:0]                  pfx_q, pfx_d;
  logic                        ov_q, ov_d;
  logic [CHAR_W-1:0]           och_q, och_d;
  logic                        olast_q, olast_d;

  logic [NDIG-1:0][3:0]        adj;
  logic [HEX_W:0]              dabble;
  logic [OCT_W-1:0]            oct_pad;
  logic [HEX_W-1:0]            hex_pad;
  logic                        out_free;

  assign out_free = !ov_q || out_o.ready;
  assign oct_pad  = OCT_W'(q_value_i);
  assign hex_pad  = HEX_W'(q_value_i);

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
    end
  end

  assign dabble = {adj, val_q[VALUE_BITS-1]};

  always_comb begin
    state_d   = state_q;
    dig_d     = dig_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    ndig_d    = ndig_q;
    cmd_d     = cmd_q;
    pfx_d     = pfx_q;
    ov_d      = ov_q && !out_o.ready;
    och_d     = och_q;
    olast_d   = olast_q;
    q_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          cmd_d  = q_ctl_i.cmd;
          pfx_d  = q_ctl_i.pfx_cnt;
          ndig_d = NDIG_W'(NDIG);
          unique case (q_ctl_i.cmd)
            CMD_DEC: begin
              dig_d   = '0;
              val_d   = q_value_i;
              cnt_d   = '0;
              state_d = ST_CONV;
            end
            CMD_OCT: begin
              for (int i = 0; i < NDIG; i++) begin
                dig_d[i] = {1'b0, oct_pad[3*i +: 3]};
              end
              state_d = ST_STRIP;
            end
            default: begin
              for (int i = 0; i < NDIG; i++) begin
                dig_d[i] = hex_pad[4*i +: 4];
              end
              state_d = ST_STRIP;
            end
          endcase
        end
      end

      ST_CONV: begin
        // adjust digits, then shift in the next value bit
        dig_d = dabble[HEX_W-1:0];
        val_d = val_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          state_d = ST_STRIP;
        end
      end

      ST_STRIP: begin
        // drop leading zeros, keep at least one digit
        if ((dig_q[NDIG-1] == 4'd0) && (ndig_q != NDIG_W'(1))) begin
          dig_d  = {dig_q[NDIG-2:0], 4'h0};
          ndig_d = ndig_q - NDIG_W'(1);
        end else begin
          state_d = (pfx_q != 2'd0) ? ST_PFX : ST_EMIT;
        end
      end

      ST_PFX: begin
        if (out_free) begin
          ov_d    = 1'b1;
          olast_d = 1'b0;
          if ((pfx_q == 2'd2) || (cmd_q == CMD_OCT)) begin
            och_d = ASCII_ZERO;
          end else begin
            och_d = (cmd_q == CMD_HEX_UP) ? ASCII_UPPER_X : ASCII_LOWER_X;
          end
          pfx_d = pfx_q - 2'd1;
          if (pfx_q == 2'd1) begin
            state_d = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          och_d   = digit_char(dig_q[NDIG-1], cmd_q == CMD_HEX_UP);
          olast_d = (ndig_q == NDIG_W'(1));
          dig_d   = {dig_q[NDIG-2:0], 4'h0};
          ndig_d  = ndig_q - NDIG_W'(1);
          if (ndig_q == NDIG_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      dig_q   <= '0;
      val_q   <= '0;
      cnt_q   <= '0;
      ndig_q  <= '0;
      cmd_q   <= CMD_DEC;
      pfx_q   <= 2'd0;
      och_q   <= '0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      dig_q   <= dig_d;
      val_q   <= val_d;
      cnt_q   <= cnt_d;
      ndig_q  <= ndig_d;
      cmd_q   <= cmd_d;
      pfx_q   <= pfx_d;
      och_q   <= och_d;
      olast_q <= olast_d;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.char_out = och_q;
  assign out_o.last     = olast_q;

endmodule

`default_nettype wire

/* bench/tb_unsigned_to_ascii_radix.sv */
// Self-checking bench for unsigned_to_ascii_radix: directed table, then random requests.
// Needs uar_pkg, uar_in_if/uar_out_if and the formatter RTL; characters are checked in order
// against the table text or, where that is empty, a local predictor of printf-style unsigned formatting.
`timescale 1ns / 100ps

module tb_unsigned_to_ascii_radix;
  import uar_pkg::*;

  localparam int unsigned VALUE_BITS   = 64;
  localparam int unsigned MAX_CHARS    = 23;
  localparam int unsigned NUM_DIR      = 22;
  localparam int unsigned NUM_RANDOM   = 148;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [1:0]  SIZE_SPARE   = 2'd3;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } fmt_char_t;

  typedef struct {
    cmd_e        cmd;
    logic [63:0] value;
    logic [1:0]  size_mode;
    logic        alt;
    string       text;
  } dir_row_t;

  // Empty text: take the expectation from the predictor.
  dir_row_t dir_tab [NUM_DIR] = '{
    '{CMD_DEC,    64'd0,                    SIZE_LONG,  1'b0, "0"},
    '{CMD_DEC,    ALL_ONES,                 SIZE_LONG,  1'b0, "18446744073709551615"},
    '{CMD_OCT,    ALL_ONES,                 SIZE_LONG,  1'b1, "01777777777777777777777"},
    '{CMD_HEX_LO, ALL_ONES,                 SIZE_LONG,  1'b1, "0xffffffffffffffff"},
    '{CMD_HEX_UP, ALL_ONES,                 SIZE_LONG,  1'b1, "0XFFFFFFFFFFFFFFFF"},
    '{CMD_DEC,    ALL_ONES,                 SIZE_INT,   1'b0, "4294967295"},
    '{CMD_DEC,    ALL_ONES,                 SIZE_SHORT, 1'b0, "65535"},
    '{CMD_DEC,    ALL_ONES,                 SIZE_SPARE, 1'b1, "18446744073709551615"},
    '{CMD_HEX_LO, 64'h0000_0000_0001_0000,  SIZE_SHORT, 1'b1, "0x0"},
    '{CMD_OCT,    64'h0000_0001_0000_0000,  SIZE_INT,   1'b1, "00"},
    '{CMD_HEX_UP, 64'h8000_0000_0000_0000,  SIZE_INT,   1'b1, "0X0"},
    '{CMD_DEC,    64'd12345,                SIZE_INT,   1'b1, "12345"},
    '{CMD_OCT,    64'd0,                    SIZE_LONG,  1'b1, "0"},
    '{CMD_HEX_UP, 64'd0,                    SIZE_SHORT, 1'b1, "0"},
    '{CMD_OCT,    64'd8,                    SIZE_INT,   1'b0, "10"},
    '{CMD_OCT,    64'd7,                    SIZE_INT,   1'b1, "07"},
    '{CMD_HEX_UP, 64'h0123_4567_89AB_CDEF,  SIZE_LONG,  1'b0, "123456789ABCDEF"},
    '{CMD_HEX_LO, 64'h0123_4567_89AB_CDEF,  SIZE_INT,   1'b1, "0x89abcdef"},
    '{CMD_DEC,    64'h8000_0000_0000_0000,  SIZE_LONG,  1'b0, ""},
    '{CMD_OCT,    64'h8000_0000_0000_0000,  SIZE_SPARE, 1'b0, ""},
    '{CMD_HEX_LO, 64'hDEAD_BEEF_CAFE_F00D,  SIZE_SHORT, 1'b0, ""},
    '{CMD_DEC,    64'h0000_0000_FFFF_0009,  SIZE_SHORT, 1'b1, ""}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  uar_in_if  req_bus ();
  uar_out_if chr_bus ();

  unsigned_to_ascii_radix #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (chr_bus)
  );

  fmt_char_t   pending_chars [$];
  string       typed_text [$];
  int unsigned error_count = 0;
  int unsigned chars_seen  = 0;
  int unsigned cycle_count = 0;
  bit          long_hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  task automatic queue_text(input string text);
    fmt_char_t c;
    for (int k = 0; k < text.len(); k++) begin
      c.ch   = text[k];
      c.last = (k == text.len() - 1);
      pending_chars.push_back(c);
    end
  endtask

  // Format the request and queue its characters, most significant first.
  task automatic predict_format(input cmd_e cmd, input logic [63:0] raw,
                                input logic [1:0] size_mode, input logic alt);
    logic [63:0]       whole;
    logic [63:0]       num;
    logic [63:0]       base;
    logic [CHAR_W-1:0] rev [MAX_CHARS];
    string             digits;
    int                n;
    fmt_char_t         c;
    whole  = raw & (ALL_ONES >> (64 - VALUE_BITS));
    case (size_mode)
      SIZE_INT:   num = {32'b0, whole[31:0]};
      SIZE_SHORT: num = {48'b0, whole[15:0]};
      default:    num = whole;
    endcase
    base   = (cmd == CMD_DEC) ? 64'd10 : (cmd == CMD_OCT) ? 64'd8 : 64'd16;
    digits = (cmd == CMD_HEX_UP) ? "0123456789ABCDEF" : "0123456789abcdef";
    n = 0;
    if (num == 0) begin
      rev[n] = "0";
      n++;
    end
    while (num != 0 && n < MAX_CHARS) begin
      rev[n] = digits[int'(num % base)];
      n++;
      num = num / base;
    end
    // Prefix follows the uncut value, so a value cut to zero still gets it.
    if (alt && whole != 0) begin
      if (cmd == CMD_OCT && n < MAX_CHARS) begin
        rev[n] = "0";
        n++;
      end else if ((cmd == CMD_HEX_LO || cmd == CMD_HEX_UP) && n + 2 <= MAX_CHARS) begin
        rev[n]     = (cmd == CMD_HEX_UP) ? ASCII_UPPER_X : ASCII_LOWER_X;
        rev[n + 1] = "0";
        n += 2;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.ch   = rev[k];
      c.last = (k == 0);
      pending_chars.push_back(c);
    end
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return r;
      1:       return 64'($urandom_range(0, 20));
      2:       return r & (ALL_ONES >> $urandom_range(0, 63));
      3:       return r << $urandom_range(16, 48);
      4:       return ALL_ONES >> $urandom_range(0, 63);
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  // Offer one request and hold it until accepted.
  task automatic send_request(input cmd_e cmd, input logic [63:0] value,
                              input logic [1:0] size_mode, input logic alt,
                              input string text, input bit calm);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_text.push_back(text);
    req_bus.valid     <= 1'b1;
    req_bus.cmd       <= cmd;
    req_bus.value     <= value;
    req_bus.size_mode <= size_mode;
    req_bus.alt_form  <= alt;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  // Scoreboard: predict on request accept, compare on character accept.
  always @(posedge clk_i) begin
    string     text;
    fmt_char_t want;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        text = typed_text.pop_front();
        if (text.len() != 0) begin
          queue_text(text);
        end else begin
          predict_format(cmd_e'(req_bus.cmd), req_bus.value, req_bus.size_mode,
                         req_bus.alt_form);
        end
      end
      if (chr_bus.valid && chr_bus.ready) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected char: expected none, actual %h last %b",
                   $time, chr_bus.char_out, chr_bus.last);
          error_count++;
        end else begin
          want = pending_chars.pop_front();
          if (chr_bus.char_out !== want.ch) begin
            $display("%0t: char_out mismatch: expected %h, actual %h",
                     $time, want.ch, chr_bus.char_out);
            error_count++;
          end
          if (chr_bus.last !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, chr_bus.last);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Character receiver: random stalls, calm stretches, one long hold-off.
  initial begin
    int unsigned gap;
    chr_bus.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        chr_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = ((chars_seen / 60) % 3 == 2) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        chr_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      chr_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!chr_bus.valid) @(posedge clk_i);
      chars_seen++;
    end
  end

  initial begin
    req_bus.valid     = 1'b0;
    req_bus.cmd       = CMD_DEC;
    req_bus.value     = '0;
    req_bus.size_mode = SIZE_INT;
    req_bus.alt_form  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].cmd, dir_tab[i].value, dir_tab[i].size_mode,
                   dir_tab[i].alt, dir_tab[i].text, 1'b0);
    end

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == 40) long_hold_req = 1'b1;
      if (k == 110) begin
        // Drain everything before going on.
        req_bus.valid <= 1'b0;
        @(posedge clk_i);
        while (pending_chars.size() != 0) @(posedge clk_i);
      end
      send_request(cmd_e'($urandom_range(0, 3)), pick_value(),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), "",
                   (k / 25) % 2 == 1);
    end

    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
